// ===== hw/rtl/sgi_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan gap interpolator package
// Field widths, defaults, transaction types and sequencer states.
// ----------------------------------------------------------------------------
package sgi_pkg;

	localparam int INDEX_W        = 11;
	localparam int RANGE_W        = 16;
	localparam int GAP_W          = 5;
	localparam int DEN_W          = GAP_W + 1;
	localparam int SCAN_SIZE_DEF  = 2048;
	localparam int RANGE_BITS_DEF = 16;

	localparam logic [GAP_W-1:0] MAX_GAP_RESET = GAP_W'(2);

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic               missing;
		logic               last;
	} sgi_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [RANGE_W-1:0] range_out;
		logic               no_return;
		logic               filled;
		logic               end_of_run;
		logic               end_of_scan;
	} sgi_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_DIV,
		ST_EMIT
	} sgi_state_t;

endpackage

// ===== hw/rtl/sgi_div.sv =====
// ----------------------------------------------------------------------------
// Scan gap interpolator divider
// Restoring divider, one quotient bit per cycle, for small divisors.
// ----------------------------------------------------------------------------
module sgi_div #(
	parameter int NUM_W = 21,
	parameter int RW    = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [sgi_pkg::DEN_W-1:0] den,
	output logic                     done,
	output logic [RW-1:0]            quo
);

	localparam int DW = sgi_pkg::DEN_W;
	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0] work_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             ge;
	logic [DW:0]      diff;

	always_comb begin
		trial = {rem_q, work_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = work_q[RW-1:0];

endmodule

// ===== hw/rtl/scan_gap_interpolator.sv =====
// ----------------------------------------------------------------------------
// Scan gap interpolator
// Fills short missing runs of a circular range scan by linear interpolation.
// ----------------------------------------------------------------------------
// One sample is taken per transaction and the block stays busy until the
// last result it causes sits in the output register. Each direct result
// passes through the SEG and EMIT states; each interpolated result also
// passes through MUL_HI, MUL_LO and DIV, which use the shared multiplier
// twice and the restoring divider that yields one quotient bit per cycle.
// A gap at the start of the scan no longer than the configured maximum is held
// and emitted with the scan's last sample, so results can leave index order.
// The configuration port is always ready.
module scan_gap_interpolator #(
	parameter int SCAN_SIZE  = sgi_pkg::SCAN_SIZE_DEF,
	parameter int RANGE_BITS = sgi_pkg::RANGE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  sgi_pkg::sgi_in_t          sample,
	output logic                      result_valid,
	input  logic                      result_ready,
	output sgi_pkg::sgi_out_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sgi_pkg::GAP_W-1:0] cfg_data
);

	localparam int IW        = sgi_pkg::INDEX_W;
	localparam int GW        = sgi_pkg::GAP_W;
	localparam int DW        = sgi_pkg::DEN_W;
	localparam int RNG_W     = sgi_pkg::RANGE_W;
	localparam int RW        = (RANGE_BITS < RNG_W) ? RANGE_BITS : RNG_W;
	localparam int NUM_W     = RW + GW;
	localparam int PW        = RW + DW;
	localparam int IDX_LIM   = (1 << IW) - 1;
	localparam int IDX_MAX_I = (SCAN_SIZE - 1 < IDX_LIM) ? SCAN_SIZE - 1 : IDX_LIM;
	localparam logic [IW-1:0] IDX_MAX = IW'(IDX_MAX_I);

	sgi_pkg::sgi_state_t state_q, state_d;

	logic [GW-1:0] mg_q;

	logic [IW-1:0] cnt_q;
	logic [IW-1:0] gap_q;
	logic [RW-1:0] prev_q;
	logic          seen_q;
	logic [GW-1:0] lead_len_q;
	logic [RW-1:0] first_q;
	logic          lead_pend_q;

	logic [IW-1:0] cur_q;
	logic          last_q;
	logic          miss_q;
	logic [RW-1:0] r_item_q;
	logic          has_v_q;
	logic          has_l_q;
	logic [GW-1:0] lead_g_q;
	logic [RW-1:0] lead_v1_q;

	logic [DW-1:0] run_k_q;
	logic [IW-1:0] run_anchor_q;
	logic [GW-1:0] run_g_q;
	logic          run_interp_q;
	logic [RW-1:0] run_v0_q;
	logic [RW-1:0] run_v1_q;

	logic [NUM_W-1:0]  acc_q;
	sgi_pkg::sgi_out_t out_q;
	logic              out_valid_q;

	logic          fire;
	logic [RW-1:0] r_in;
	logic [DW-1:0] mg_p1;
	logic [IW-1:0] gap_inc;
	logic          gap_fill;
	logic [DW-1:0] a_cnt;
	logic [IW-1:0] a_anchor;
	logic          a_interp;
	logic [IW-1:0] gap_d;
	logic [RW-1:0] prev_d;
	logic [RW-1:0] first_d;
	logic          lead_pend_d;
	logic [GW-1:0] lead_len_d;

	logic          load_l;
	logic          emit_go;
	logic          div_start;
	logic          div_done;
	logic [RW-1:0] quo;

	logic [DW-1:0]    den;
	logic [RW-1:0]    mul_a;
	logic [DW-1:0]    mul_b;
	logic [PW-1:0]    prod;
	logic [NUM_W-1:0] prod_n;
	logic [NUM_W-1:0] div_num;

	sgi_pkg::sgi_out_t out_d;
	logic              out_final;

	assign fire      = sample_valid && sample_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		r_in        = sample.range[RW-1:0];
		mg_p1       = {1'b0, mg_q} + DW'(1);
		gap_inc     = (gap_q == '1) ? gap_q : gap_q + IW'(1);
		gap_fill    = (gap_q != '0) && (gap_q <= IW'(mg_q));
		a_cnt       = '0;
		a_anchor    = cnt_q;
		a_interp    = 1'b0;
		gap_d       = gap_q;
		prev_d      = prev_q;
		first_d     = first_q;
		lead_pend_d = lead_pend_q;
		lead_len_d  = lead_len_q;
		if (sample.missing) begin
			gap_d    = gap_inc;
			a_anchor = cnt_q + IW'(1);
			if (gap_inc == IW'(mg_p1)) begin
				a_cnt = DW'(gap_inc);
			end else if (gap_inc > IW'(mg_p1)) begin
				a_cnt = DW'(1);
			end else if (sample.last) begin
				a_cnt = DW'(gap_inc);
			end
		end else begin
			if (gap_fill) begin
				if (seen_q) begin
					a_cnt    = DW'(gap_q);
					a_interp = 1'b1;
				end else begin
					lead_pend_d = 1'b1;
					lead_len_d  = GW'(gap_q);
				end
			end
			if (!seen_q) begin
				first_d = r_in;
			end
			prev_d = r_in;
			gap_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mg_q <= sgi_pkg::MAX_GAP_RESET;
		end else if (cfg_valid) begin
			mg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			gap_q       <= '0;
			prev_q      <= '0;
			seen_q      <= 1'b0;
			lead_len_q  <= '0;
			first_q     <= '0;
			lead_pend_q <= 1'b0;
		end else if (fire) begin
			if (sample.last) begin
				cnt_q       <= '0;
				gap_q       <= '0;
				prev_q      <= '0;
				seen_q      <= 1'b0;
				lead_len_q  <= '0;
				first_q     <= '0;
				lead_pend_q <= 1'b0;
			end else begin
				gap_q       <= gap_d;
				prev_q      <= prev_d;
				seen_q      <= seen_q || !sample.missing;
				lead_len_q  <= lead_len_d;
				first_q     <= first_d;
				lead_pend_q <= lead_pend_d;
				if (cnt_q < IDX_MAX) begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cur_q     <= cnt_q;
			last_q    <= sample.last;
			miss_q    <= sample.missing;
			r_item_q  <= r_in;
			lead_g_q  <= lead_len_d;
			lead_v1_q <= first_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgi_pkg::ST_IDLE;
			has_v_q <= 1'b0;
			has_l_q <= 1'b0;
			run_k_q <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				has_v_q <= !sample.missing;
				has_l_q <= sample.last && lead_pend_d;
				run_k_q <= a_cnt;
			end else if (load_l) begin
				has_l_q <= 1'b0;
				run_k_q <= DW'(lead_g_q);
			end else if (emit_go) begin
				if (run_k_q != '0) begin
					run_k_q <= run_k_q - DW'(1);
				end else begin
					has_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			run_anchor_q <= a_anchor;
			run_g_q      <= GW'(gap_q);
			run_interp_q <= a_interp;
			run_v0_q     <= prev_q;
			run_v1_q     <= r_in;
		end else if (load_l) begin
			run_anchor_q <= IW'(lead_g_q);
			run_g_q      <= lead_g_q;
			run_interp_q <= !miss_q;
			run_v0_q     <= r_item_q;
			run_v1_q     <= lead_v1_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		load_l       = 1'b0;
		emit_go      = 1'b0;
		div_start    = 1'b0;
		unique case (state_q)
			sgi_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = sgi_pkg::ST_SEG;
				end
			end
			sgi_pkg::ST_SEG: begin
				priority if (run_k_q != '0) begin
					state_d = run_interp_q ? sgi_pkg::ST_MUL_HI : sgi_pkg::ST_EMIT;
				end else if (has_v_q) begin
					state_d = sgi_pkg::ST_EMIT;
				end else if (has_l_q) begin
					load_l = 1'b1;
				end else begin
					state_d = sgi_pkg::ST_IDLE;
				end
			end
			sgi_pkg::ST_MUL_HI: begin
				state_d = sgi_pkg::ST_MUL_LO;
			end
			sgi_pkg::ST_MUL_LO: begin
				div_start = 1'b1;
				state_d   = sgi_pkg::ST_DIV;
			end
			sgi_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sgi_pkg::ST_EMIT;
				end
			end
			sgi_pkg::ST_EMIT: begin
				if (!out_valid_q || result_ready) begin
					emit_go = 1'b1;
					state_d = sgi_pkg::ST_SEG;
				end
			end
			default: begin
				state_d = sgi_pkg::ST_IDLE;
			end
		endcase
	end

	// Shared multiplier: v1*(d-k) first, then v0*k.
	always_comb begin
		den     = {1'b0, run_g_q} + DW'(1);
		mul_a   = (state_q == sgi_pkg::ST_MUL_HI) ? run_v1_q : run_v0_q;
		mul_b   = (state_q == sgi_pkg::ST_MUL_HI) ? den - run_k_q : run_k_q;
		prod    = {{DW{1'b0}}, mul_a} * {{RW{1'b0}}, mul_b};
		prod_n  = prod[NUM_W-1:0];
		div_num = acc_q + prod_n;
	end

	always_ff @(posedge clk) begin
		if (state_q == sgi_pkg::ST_MUL_HI) begin
			acc_q <= prod_n + NUM_W'(den >> 1);
		end
	end

	sgi_div #(
		.NUM_W (NUM_W),
		.RW    (RW)
	) u_sgi_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		if (run_k_q != '0) begin
			out_final       = (run_k_q == DW'(1)) && !has_v_q && !has_l_q;
			out_d.index     = run_anchor_q - IW'(run_k_q);
			out_d.range_out = run_interp_q ? RNG_W'(quo) : '0;
			out_d.no_return = !run_interp_q;
			out_d.filled    = run_interp_q;
		end else begin
			out_final       = !has_l_q;
			out_d.index     = cur_q;
			out_d.range_out = RNG_W'(r_item_q);
			out_d.no_return = 1'b0;
			out_d.filled    = 1'b0;
		end
		out_d.end_of_run  = out_final;
		out_d.end_of_scan = out_final && last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hw/rtl/sgi_checker.sv =====
// ----------------------------------------------------------------------------
// Scan gap interpolator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sgi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              result_valid,
	input logic              result_ready,
	input sgi_pkg::sgi_out_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while previous transaction in work");

	a_scan_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_scan |-> result.end_of_run)
		else $error("end of scan without end of run");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.no_return && result.filled))
		else $error("result both filled and without return");

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.no_return |-> result.range_out == '0)
		else $error("missing result carries a range");

endmodule

bind scan_gap_interpolator sgi_checker u_sgi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
